// ===== src/tgss_pkg.sv =====
package tgss_pkg;

	localparam int unsigned POS_MAX = 15;

	localparam logic [15:0] X_STEPS_RST = 16'd6500;
	localparam logic [15:0] Y_STEPS_RST = 16'd4800;
	localparam logic [15:0] HALF_RST    = 16'd100;
	localparam logic [19:0] SHORT_RST   = 20'd50000;
	localparam logic [19:0] LONG_RST    = 20'd500000;

	localparam int unsigned CFG_W   = 20;
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_STEPS = 3'd0,
		REG_Y_STEPS = 3'd1,
		REG_HALF    = 3'd2,
		REG_SHORT   = 3'd3,
		REG_LONG    = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		PH_X_SEEK  = 4'd0,
		PH_X_SHORT = 4'd1,
		PH_X_BACK  = 4'd2,
		PH_H_LONG  = 4'd3,
		PH_Y_SEEK  = 4'd4,
		PH_Y_SHORT = 4'd5,
		PH_Y_BACK  = 4'd6,
		PH_IDLE    = 4'd7,
		PH_MOVE_X  = 4'd8,
		PH_M_LONG  = 4'd9,
		PH_MOVE_Y  = 4'd10
	} phase_t;

	typedef struct packed {
		logic [15:0] x_steps_per_cell;
		logic [15:0] y_steps_per_cell;
		logic [15:0] pulse_half_ticks;
		logic [19:0] short_pause_ticks;
		logic [19:0] long_pause_ticks;
	} cfg_t;

	typedef struct packed {
		logic       op;
		logic [3:0] target_x;
		logic [3:0] target_y;
		logic       x_endstop_open;
		logic       y_endstop_open;
	} item_t;

	typedef struct packed {
		logic x_step;
		logic x_dir;
		logic y_step;
		logic y_dir;
		logic busy_res;
		logic homed;
		logic cmd_rejected;
	} res_t;

	function automatic logic [3:0] sat_pos(input logic [3:0] v);
		logic [7:0] lim;
		lim = 8'(POS_MAX);
		return ({4'd0, v} > lim) ? lim[3:0] : v;
	endfunction

endpackage

// ===== src/two_axis_grid_stepper_sequencer.sv =====
// Two-axis grid stepper sequencer. Each input item is either one time tick
// (op 0, carrying the two endstop levels) or a move command (op 1, carrying a
// target grid cell). After reset the block homes X then Y: seek the endstop
// with direction low, short pause, back off with direction high until the
// endstop releases, with a long pause between the axes. Once homed, a move
// steps X by x_steps_per_cell per cell of distance, waits the long pause, then
// steps Y. One result item comes out for every input item, showing the step
// and direction levels, busy, homed and whether a command was rejected.
// Items flow at one per clock unless out_ready stalls, through the input
// register, next-state logic and result register. The user must write
// configuration via cfg_we/cfg_idx/cfg_wdata while idle; nothing checks it.
module two_axis_grid_stepper_sequencer (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [tgss_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [tgss_pkg::CFG_W-1:0]      cfg_wdata,
	// input item channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            op,
	input  logic [3:0]                      target_x,
	input  logic [3:0]                      target_y,
	input  logic                            x_endstop_open,
	input  logic                            y_endstop_open,
	// result item channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            x_step,
	output logic                            x_dir,
	output logic                            y_step,
	output logic                            y_dir,
	output logic                            busy_res,
	output logic                            homed,
	output logic                            cmd_rejected
);
	import tgss_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res_d;
	res_t  res_s2;
	logic  valid_s2;
	logic  fire;

	// stage 2 frees when empty or when its item is taken this cycle
	assign fire     = valid_s1 && (!valid_s2 || out_ready);
	// stage 1 takes a new item when empty or when it moves on
	assign in_ready = !valid_s1 || fire;

	tgss_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.op             <= op;
			item_s1.target_x       <= target_x;
			item_s1.target_y       <= target_y;
			item_s1.x_endstop_open <= x_endstop_open;
			item_s1.y_endstop_open <= y_endstop_open;
		end
	end

	// sequencer state and single-pass next-state logic
	tgss_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid    = valid_s2;
	assign x_step       = res_s2.x_step;
	assign x_dir        = res_s2.x_dir;
	assign y_step       = res_s2.y_step;
	assign y_dir        = res_s2.y_dir;
	assign busy_res     = res_s2.busy_res;
	assign homed        = res_s2.homed;
	assign cmd_rejected = res_s2.cmd_rejected;

endmodule

// ===== src/tgss_cfg.sv =====
module tgss_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tgss_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [tgss_pkg::CFG_W-1:0]      cfg_wdata,
	output tgss_pkg::cfg_t                  cfg
);
	import tgss_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_steps_per_cell  <= X_STEPS_RST;
			cfg_q.y_steps_per_cell  <= Y_STEPS_RST;
			cfg_q.pulse_half_ticks  <= HALF_RST;
			cfg_q.short_pause_ticks <= SHORT_RST;
			cfg_q.long_pause_ticks  <= LONG_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_X_STEPS: cfg_q.x_steps_per_cell  <= cfg_wdata[15:0];
				REG_Y_STEPS: cfg_q.y_steps_per_cell  <= cfg_wdata[15:0];
				REG_HALF:    cfg_q.pulse_half_ticks  <= cfg_wdata[15:0];
				REG_SHORT:   cfg_q.short_pause_ticks <= cfg_wdata;
				REG_LONG:    cfg_q.long_pause_ticks  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/tgss_seq.sv =====
module tgss_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  tgss_pkg::item_t item,
	input  tgss_pkg::cfg_t  cfg,
	output tgss_pkg::res_t  res
);
	import tgss_pkg::*;

	phase_t      phase_q, phase_d;
	logic [3:0]  x_pos_q, x_pos_d, y_pos_q, y_pos_d;
	logic [3:0]  x_goal_q, x_goal_d, y_goal_q, y_goal_d;
	logic [3:0]  cells_q, cells_d;
	logic [15:0] steps_q, steps_d;
	logic [15:0] half_q, half_d;
	logic [19:0] pause_q, pause_d;
	logic        pulse_q, pulse_d;
	logic        x_dir_q, x_dir_d, y_dir_q, y_dir_d;
	logic        homed_q, homed_d;
	logic        rej_d;

	logic [15:0] reload;
	logic        mv_axis_y;
	logic [15:0] per_cell;
	logic [3:0]  cl_m;
	logic [15:0] sl_m;
	logic [3:0]  tx, ty;

	// zero half period behaves as one tick
	assign reload  = (cfg.pulse_half_ticks == 16'd0) ? 16'd0 : cfg.pulse_half_ticks - 16'd1;

	// cell refill for the active move axis
	assign mv_axis_y = (phase_q == PH_MOVE_Y);
	assign per_cell  = mv_axis_y ? cfg.y_steps_per_cell : cfg.x_steps_per_cell;
	assign cl_m = (steps_q == 16'd0 && cells_q != 4'd0) ? cells_q - 4'd1 : cells_q;
	assign sl_m = (steps_q == 16'd0 && cells_q != 4'd0) ? per_cell : steps_q;

	assign tx = sat_pos(item.target_x);
	assign ty = sat_pos(item.target_y);

	// next state
	always_comb begin
		phase_d  = phase_q;
		x_pos_d  = x_pos_q;
		y_pos_d  = y_pos_q;
		x_goal_d = x_goal_q;
		y_goal_d = y_goal_q;
		cells_d  = cells_q;
		steps_d  = steps_q;
		half_d   = half_q;
		pause_d  = pause_q;
		pulse_d  = pulse_q;
		x_dir_d  = x_dir_q;
		y_dir_d  = y_dir_q;
		homed_d  = homed_q;
		rej_d    = 1'b0;

		if (item.op) begin
			if (phase_q == PH_IDLE && homed_q) begin
				x_goal_d = tx;
				y_goal_d = ty;
				steps_d  = 16'd0;
				if (tx > x_pos_q) begin
					x_dir_d = 1'b1;
					cells_d = tx - x_pos_q;
				end else if (tx < x_pos_q) begin
					x_dir_d = 1'b0;
					cells_d = x_pos_q - tx;
				end else begin
					cells_d = 4'd0;
				end
				phase_d = PH_MOVE_X;
			end else begin
				rej_d = 1'b1;
			end
		end else begin
			case (phase_q)
				PH_X_SEEK, PH_X_BACK, PH_Y_SEEK, PH_Y_BACK, PH_MOVE_X, PH_MOVE_Y: begin
					if (half_q != 16'd0) begin
						half_d = half_q - 16'd1;
					end else if (pulse_q) begin
						pulse_d = 1'b0;
						half_d  = reload;
					end else begin
						case (phase_q)
							PH_X_SEEK: begin
								if (item.x_endstop_open) begin
									pulse_d = 1'b1;
									half_d  = reload;
								end else begin
									pause_d = cfg.short_pause_ticks;
									phase_d = PH_X_SHORT;
								end
							end
							PH_X_BACK: begin
								if (!item.x_endstop_open) begin
									pulse_d = 1'b1;
									half_d  = reload;
								end else begin
									pause_d = cfg.long_pause_ticks;
									phase_d = PH_H_LONG;
								end
							end
							PH_Y_SEEK: begin
								if (item.y_endstop_open) begin
									pulse_d = 1'b1;
									half_d  = reload;
								end else begin
									pause_d = cfg.short_pause_ticks;
									phase_d = PH_Y_SHORT;
								end
							end
							PH_Y_BACK: begin
								if (!item.y_endstop_open) begin
									pulse_d = 1'b1;
									half_d  = reload;
								end else begin
									homed_d = 1'b1;
									phase_d = PH_IDLE;
								end
							end
							default: begin
								// move axis: refill from the next cell, then step or finish
								cells_d = cl_m;
								if (sl_m != 16'd0) begin
									steps_d = sl_m - 16'd1;
									pulse_d = 1'b1;
									half_d  = reload;
								end else begin
									steps_d = sl_m;
									if (mv_axis_y) begin
										x_pos_d = x_goal_q;
										y_pos_d = y_goal_q;
										phase_d = PH_IDLE;
									end else begin
										pause_d = cfg.long_pause_ticks;
										phase_d = PH_M_LONG;
									end
								end
							end
						endcase
					end
				end
				PH_X_SHORT, PH_Y_SHORT, PH_H_LONG, PH_M_LONG: begin
					if (pause_q != 20'd0) begin
						pause_d = pause_q - 20'd1;
					end else begin
						case (phase_q)
							PH_X_SHORT: begin
								x_dir_d = 1'b1;
								phase_d = PH_X_BACK;
							end
							PH_Y_SHORT: begin
								y_dir_d = 1'b1;
								phase_d = PH_Y_BACK;
							end
							PH_H_LONG: phase_d = PH_Y_SEEK;
							default: begin
								steps_d = 16'd0;
								if (y_goal_q > y_pos_q) begin
									y_dir_d = 1'b1;
									cells_d = y_goal_q - y_pos_q;
								end else if (y_goal_q < y_pos_q) begin
									y_dir_d = 1'b0;
									cells_d = y_pos_q - y_goal_q;
								end else begin
									cells_d = 4'd0;
								end
								phase_d = PH_MOVE_Y;
							end
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	// outputs from the updated state
	always_comb begin
		res.x_step       = (phase_d inside {PH_X_SEEK, PH_X_BACK, PH_MOVE_X}) ? pulse_d : 1'b0;
		res.y_step       = (phase_d inside {PH_Y_SEEK, PH_Y_BACK, PH_MOVE_Y}) ? pulse_d : 1'b0;
		res.x_dir        = x_dir_d;
		res.y_dir        = y_dir_d;
		res.busy_res     = (phase_d != PH_IDLE);
		res.homed        = homed_d;
		res.cmd_rejected = rej_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_X_SEEK;
			x_pos_q  <= '0;
			y_pos_q  <= '0;
			x_goal_q <= '0;
			y_goal_q <= '0;
			cells_q  <= '0;
			steps_q  <= '0;
			half_q   <= '0;
			pause_q  <= '0;
			pulse_q  <= 1'b0;
			x_dir_q  <= 1'b0;
			y_dir_q  <= 1'b0;
			homed_q  <= 1'b0;
		end else if (fire) begin
			phase_q  <= phase_d;
			x_pos_q  <= x_pos_d;
			y_pos_q  <= y_pos_d;
			x_goal_q <= x_goal_d;
			y_goal_q <= y_goal_d;
			cells_q  <= cells_d;
			steps_q  <= steps_d;
			half_q   <= half_d;
			pause_q  <= pause_d;
			pulse_q  <= pulse_d;
			x_dir_q  <= x_dir_d;
			y_dir_q  <= y_dir_d;
			homed_q  <= homed_d;
		end
	end

endmodule

// ===== src/tgss_checker.sv =====
module tgss_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic x_step,
	input logic x_dir,
	input logic y_step,
	input logic y_dir,
	input logic busy_res,
	input logic homed,
	input logic cmd_rejected
);

	// a stalled item holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(x_step) && $stable(y_step)
			&& $stable(x_dir) && $stable(y_dir) && $stable(homed))
		else $error("result item changed while stalled");

	// only one axis pulses at a time
	a_one_axis: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(x_step && y_step))
		else $error("both axes stepping");

	// idle is only reached after homing
	a_idle_homed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> homed)
		else $error("idle without homing");

	// homed stays set once shown
	a_homed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && homed |=> !out_valid || homed)
		else $error("homed dropped");

	// a rejected command never starts stepping in its own item
	a_rej_nostep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cmd_rejected && homed |-> busy_res || (!x_step && !y_step))
		else $error("rejected command stepped");

endmodule

bind two_axis_grid_stepper_sequencer tgss_checker u_tgss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.x_step       (x_step),
	.x_dir        (x_dir),
	.y_step       (y_step),
	.y_dir        (y_dir),
	.busy_res     (busy_res),
	.homed        (homed),
	.cmd_rejected (cmd_rejected)
);

// ===== tb/sv/two_axis_grid_stepper_sequencer_tb.sv =====
`timescale 1ns / 1ps

module two_axis_grid_stepper_sequencer_tb;
	import tgss_pkg::*;

	// op codes of an input item
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_MOVE = 1'b1;

	localparam int ITEM_W       = $bits(item_t);
	localparam int N_LEVELS     = $bits(res_t);
	localparam int N_ROWS       = 22;
	localparam int N_PRE        = 2;    // rows run on the reset setting
	localparam int N_SETTINGS   = 6;
	localparam int SETTLE_CYCLES = 8;   // extra wait after the last expected result is back
	localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
	localparam int HOLD_AFTER   = 300;  // results seen before the hold-off starts
	localparam int unsigned LIMIT = 200000;

	// one row of the directed table; want is used only when typed is set
	typedef struct packed {
		logic  typed;
		item_t it;
		res_t  want;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 op = OP_TICK;
	logic [3:0]           target_x = '0;
	logic [3:0]           target_y = '0;
	logic                 x_endstop_open = 1'b1;
	logic                 y_endstop_open = 1'b1;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 x_step;
	logic                 x_dir;
	logic                 y_step;
	logic                 y_dir;
	logic                 busy_res;
	logic                 homed;
	logic                 cmd_rejected;

	two_axis_grid_stepper_sequencer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.target_x       (target_x),
		.target_y       (target_y),
		.x_endstop_open (x_endstop_open),
		.y_endstop_open (y_endstop_open),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.x_step         (x_step),
		.x_dir          (x_dir),
		.y_step         (y_step),
		.y_dir          (y_dir),
		.busy_res       (busy_res),
		.homed          (homed),
		.cmd_rejected   (cmd_rejected)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// axis sequencer shadow: its own copy of the setting and the state
	// ------------------------------------------------------------------
	cfg_t        cfg_m = {X_STEPS_RST, Y_STEPS_RST, HALF_RST, SHORT_RST, LONG_RST};
	phase_t      ph = PH_X_SEEK;
	logic [3:0]  xpos = '0, ypos = '0, xgoal = '0, ygoal = '0;
	logic [3:0]  cells_cnt = '0;
	logic [15:0] steps_cnt = '0;
	logic [15:0] half_cnt = '0;
	logic [19:0] ptimer = '0;
	logic        lvl = 1'b0, xdir = 1'b0, ydir = 1'b0, hflag = 1'b0;

	// levels expected on the result channel, oldest first
	res_t        levels_due[$];

	int          errors = 0;
	int          results_seen = 0;
	int          burst_left = 1;
	int unsigned cycle_count = 0;

	// reload of a half period; zero counts as one tick
	function automatic logic [15:0] half_load();
		return (cfg_m.pulse_half_ticks != 16'd0) ? cfg_m.pulse_half_ticks - 16'd1 : 16'd0;
	endfunction

	function automatic void fire_pulse();
		lvl = 1'b1;
		half_cnt = half_load();
	endfunction

	// moves a pulse in flight one tick on; 1 while one is in flight
	function automatic bit pulse_busy();
		if (half_cnt != 16'd0) begin
			half_cnt = half_cnt - 16'd1;
			return 1'b1;
		end
		if (lvl) begin
			lvl = 1'b0;
			half_cnt = half_load();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// one more step of a move leg; zero steps per cell eats cells silently
	function automatic bit take_step(logic [15:0] per_cell);
		if (steps_cnt == 16'd0 && cells_cnt != 4'd0) begin
			cells_cnt = cells_cnt - 4'd1;
			steps_cnt = per_cell;
		end
		if (steps_cnt == 16'd0)
			return 1'b0;
		steps_cnt = steps_cnt - 16'd1;
		fire_pulse();
		return 1'b1;
	endfunction

	// cells and direction of one leg; equal coordinate keeps the direction
	function automatic logic plan_leg(logic [3:0] pos, logic [3:0] goal, logic dir);
		steps_cnt = '0;
		if (goal > pos) begin
			cells_cnt = goal - pos;
			return 1'b1;
		end
		if (goal < pos) begin
			cells_cnt = pos - goal;
			return 1'b0;
		end
		cells_cnt = '0;
		return dir;
	endfunction

	// applies one accepted item and returns the levels it shows
	function automatic res_t advance_axes(item_t it);
		res_t       r;
		logic [3:0] tx;
		logic [3:0] ty;
		r = '0;
		if (it.op == OP_MOVE) begin
			// a command only gets through when homed and idle
			if (ph == PH_IDLE && hflag) begin
				tx = (int'(it.target_x) > POS_MAX) ? 4'(POS_MAX) : it.target_x;
				ty = (int'(it.target_y) > POS_MAX) ? 4'(POS_MAX) : it.target_y;
				xgoal = tx;
				ygoal = ty;
				xdir = plan_leg(xpos, xgoal, xdir);
				ph = PH_MOVE_X;
			end else begin
				r.cmd_rejected = 1'b1;
			end
		end else begin
			case (ph)
				PH_X_SEEK: if (!pulse_busy()) begin
					if (it.x_endstop_open) fire_pulse();
					else begin
						ptimer = cfg_m.short_pause_ticks;
						ph = PH_X_SHORT;
					end
				end
				PH_X_SHORT: if (ptimer != 20'd0) ptimer = ptimer - 20'd1;
				else begin
					xdir = 1'b1;
					ph = PH_X_BACK;
				end
				PH_X_BACK: if (!pulse_busy()) begin
					if (!it.x_endstop_open) fire_pulse();
					else begin
						ptimer = cfg_m.long_pause_ticks;
						ph = PH_H_LONG;
					end
				end
				PH_H_LONG: if (ptimer != 20'd0) ptimer = ptimer - 20'd1;
				else ph = PH_Y_SEEK;
				PH_Y_SEEK: if (!pulse_busy()) begin
					if (it.y_endstop_open) fire_pulse();
					else begin
						ptimer = cfg_m.short_pause_ticks;
						ph = PH_Y_SHORT;
					end
				end
				PH_Y_SHORT: if (ptimer != 20'd0) ptimer = ptimer - 20'd1;
				else begin
					ydir = 1'b1;
					ph = PH_Y_BACK;
				end
				PH_Y_BACK: if (!pulse_busy()) begin
					if (!it.y_endstop_open) fire_pulse();
					else begin
						hflag = 1'b1;
						ph = PH_IDLE;
					end
				end
				PH_MOVE_X: if (!pulse_busy()) begin
					if (!take_step(cfg_m.x_steps_per_cell)) begin
						ptimer = cfg_m.long_pause_ticks;
						ph = PH_M_LONG;
					end
				end
				PH_M_LONG: if (ptimer != 20'd0) ptimer = ptimer - 20'd1;
				else begin
					ydir = plan_leg(ypos, ygoal, ydir);
					ph = PH_MOVE_Y;
				end
				PH_MOVE_Y: if (!pulse_busy()) begin
					if (!take_step(cfg_m.y_steps_per_cell)) begin
						xpos = xgoal;
						ypos = ygoal;
						ph = PH_IDLE;
					end
				end
				default: ;
			endcase
		end
		r.x_step = (ph == PH_X_SEEK || ph == PH_X_BACK || ph == PH_MOVE_X) ? lvl : 1'b0;
		r.y_step = (ph == PH_Y_SEEK || ph == PH_Y_BACK || ph == PH_MOVE_Y) ? lvl : 1'b0;
		r.x_dir = xdir;
		r.y_dir = ydir;
		r.busy_res = (ph != PH_IDLE);
		r.homed = hflag;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// sender side
	// ------------------------------------------------------------------

	// offers one item, predicts it on acceptance, then maybe opens a gap
	task automatic offer(item_t it, logic typed, res_t want);
		res_t pred;
		in_valid <= 1'b1;
		op <= it.op;
		target_x <= it.target_x;
		target_y <= it.target_y;
		x_endstop_open <= it.x_endstop_open;
		y_endstop_open <= it.y_endstop_open;
		do @(posedge clk); while (!in_ready);
		pred = advance_axes(it);
		levels_due.push_back(typed ? want : pred);
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			// mostly short bursts, now and then a long unbroken stretch
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
				: $urandom_range(1, 16);
		end
	endtask

	// stops offering and waits until every result is back
	task automatic settle();
		in_valid <= 1'b0;
		while (levels_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// writes every register; spare upper data bits of the narrow ones get junk
	task automatic load_setting(cfg_t c);
		reg_idx_t order[5];
		order = '{REG_X_STEPS, REG_Y_STEPS, REG_HALF, REG_SHORT, REG_LONG};
		foreach (order[k]) begin
			cfg_we <= 1'b1;
			cfg_idx <= order[k];
			case (order[k])
				REG_X_STEPS: begin
					cfg_wdata <= {4'($urandom), c.x_steps_per_cell};
					cfg_m.x_steps_per_cell = c.x_steps_per_cell;
				end
				REG_Y_STEPS: begin
					cfg_wdata <= {4'($urandom), c.y_steps_per_cell};
					cfg_m.y_steps_per_cell = c.y_steps_per_cell;
				end
				REG_HALF: begin
					cfg_wdata <= {4'($urandom), c.pulse_half_ticks};
					cfg_m.pulse_half_ticks = c.pulse_half_ticks;
				end
				REG_SHORT: begin
					cfg_wdata <= c.short_pause_ticks;
					cfg_m.short_pause_ticks = c.short_pause_ticks;
				end
				default: begin
					cfg_wdata <= c.long_pause_ticks;
					cfg_m.long_pause_ticks = c.long_pause_ticks;
				end
			endcase
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic row_t dir_row(logic o, logic [3:0] tx, logic [3:0] ty,
		logic xo, logic yo, logic typed, logic [N_LEVELS-1:0] want);
		row_t r;
		r.typed = typed;
		r.it.op = o;
		r.it.target_x = tx;
		r.it.target_y = ty;
		r.it.x_endstop_open = xo;
		r.it.y_endstop_open = yo;
		r.want = want;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		row_t plan_rows[N_ROWS];
		cfg_t settings[N_SETTINGS];
		int   seg_items[N_SETTINGS];
		item_t it;
		int   pick;

		// tight timing first so that homing fits in the table
		settings[0] = {16'd2, 16'd1, 16'd1, 20'd0, 20'd0};
		// zero half period counts as one tick
		settings[1] = {16'd3, 16'd2, 16'd0, 20'd3, 20'd5};
		// zero steps per cell: cells pass without pulses
		settings[2] = {16'd0, 16'd0, 16'd2, 20'd1, 20'd0};
		settings[3] = {16'd1, 16'd4, 16'd3, 20'd0, 20'd20};
		settings[4] = {16'd5, 16'd3, 16'd2, 20'd7, 20'd60};
		// top of every range, only a handful of items
		settings[5] = {16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 20'hFFFFF};
		seg_items = '{200, 220, 170, 170, 220, 48};

		// want columns: x_step x_dir y_step y_dir busy homed rejected
		plan_rows = '{
			// commands before homing are turned away
			dir_row(OP_MOVE, 4'd0,  4'd0,  1'b0, 1'b0, 1'b1, 7'b0000101),
			dir_row(OP_MOVE, 4'd15, 4'd15, 1'b1, 1'b1, 1'b1, 7'b0000101),
			// x seek: one pulse, then the endstop triggers
			dir_row(OP_TICK, 4'd0,  4'd0,  1'b1, 1'b1, 1'b0, 7'b0),
			dir_row(OP_TICK, 4'd0,  4'd0,  1'b1, 1'b1, 1'b0, 7'b0),
			dir_row(OP_TICK, 4'd0,  4'd0,  1'b0, 1'b1, 1'b0, 7'b0),
			// zero short pause, then back off with one pulse
			dir_row(OP_TICK, 4'd0,  4'd0,  1'b0, 1'b1, 1'b0, 7'b0),
			dir_row(OP_TICK, 4'd0,  4'd0,  1'b0, 1'b1, 1'b0, 7'b0),
			dir_row(OP_TICK, 4'd0,  4'd0,  1'b0, 1'b1, 1'b0, 7'b0),
			dir_row(OP_TICK, 4'd0,  4'd0,  1'b1, 1'b1, 1'b0, 7'b0),
			// command during the long pause between axes
			dir_row(OP_MOVE, 4'd3,  4'd9,  1'b1, 1'b1, 1'b1, 7'b0100101),
			dir_row(OP_TICK, 4'd0,  4'd0,  1'b1, 1'b1, 1'b0, 7'b0),
			// y seek, endstop change while the pulse is in flight
			dir_row(OP_TICK, 4'd0,  4'd0,  1'b1, 1'b1, 1'b0, 7'b0),
			dir_row(OP_TICK, 4'd0,  4'd0,  1'b1, 1'b0, 1'b0, 7'b0),
			dir_row(OP_TICK, 4'd0,  4'd0,  1'b1, 1'b0, 1'b0, 7'b0),
			dir_row(OP_TICK, 4'd0,  4'd0,  1'b1, 1'b0, 1'b0, 7'b0),
			dir_row(OP_TICK, 4'd0,  4'd0,  1'b0, 1'b0, 1'b0, 7'b0),
			dir_row(OP_TICK, 4'd0,  4'd0,  1'b0, 1'b0, 1'b0, 7'b0),
			// endstop releases: homed and idle
			dir_row(OP_TICK, 4'd0,  4'd0,  1'b0, 1'b1, 1'b1, 7'b0101010),
			// full-width x move with y unchanged
			dir_row(OP_MOVE, 4'd15, 4'd0,  1'b0, 1'b0, 1'b0, 7'b0),
			// command while busy
			dir_row(OP_MOVE, 4'd7,  4'd7,  1'b1, 1'b0, 1'b0, 7'b0),
			dir_row(OP_TICK, 4'd15, 4'd15, 1'b0, 1'b1, 1'b0, 7'b0),
			dir_row(OP_TICK, 4'd0,  4'd15, 1'b1, 1'b0, 1'b0, 7'b0)
		};

		// reset held from the start, released once
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, first on the reset setting
		for (int i = 0; i < N_ROWS; i++) begin
			if (i == N_PRE) begin
				settle();
				load_setting(settings[0]);
			end
			offer(plan_rows[i].it, plan_rows[i].typed, plan_rows[i].want);
		end

		// random part, one segment per setting
		for (int s = 0; s < N_SETTINGS; s++) begin
			if (s != 0) begin
				settle();
				load_setting(settings[s]);
			end
			repeat (seg_items[s]) begin
				pick = $urandom_range(0, 99);
				it = ITEM_W'($urandom);
				// a few items stay pure noise
				if (pick >= 6) begin
					if (ph == PH_IDLE) begin
						it.op = ($urandom_range(0, 9) < 7) ? OP_MOVE : OP_TICK;
						// often keep one axis where it is
						case ($urandom_range(0, 3))
							0: it.target_x = xpos;
							1: it.target_y = ypos;
							default: ;
						endcase
					end else begin
						// busy: mostly ticks, a stray command now and then
						it.op = ($urandom_range(0, 24) == 0) ? OP_MOVE : OP_TICK;
					end
				end
				offer(it, 1'b0, '0);
			end
		end

		settle();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// receiver side: changing stall patterns, one long hold-off
	// ------------------------------------------------------------------
	initial begin : receiver
		int mode;
		int span;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!held && results_seen >= HOLD_AFTER) begin
				// long hold-off so the block fills and stalls its input
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(8, 64);
				repeat (span) begin
					case (mode)
						0: out_ready <= 1'b1;
						1: out_ready <= 1'($urandom);
						2: out_ready <= ($urandom_range(0, 3) == 0);
						default: out_ready <= ($urandom_range(0, 7) != 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// result check
	// ------------------------------------------------------------------
	task automatic note_mismatch(string msg);
		if (errors < 40)
			$display("mismatch: %s", msg);
		errors++;
	endtask

	string lane_name[N_LEVELS] = '{"x_step", "x_dir", "y_step", "y_dir",
		"busy_res", "homed", "cmd_rejected"};

	always @(posedge clk) begin : check_levels
		res_t got;
		res_t want;
		if (out_valid && out_ready) begin
			got = {x_step, x_dir, y_step, y_dir, busy_res, homed, cmd_rejected};
			results_seen++;
			if (levels_due.size() == 0) begin
				note_mismatch($sformatf("result %0d arrived with nothing expected",
					results_seen));
			end else begin
				want = levels_due.pop_front();
				for (int i = 0; i < N_LEVELS; i++)
					if (got[N_LEVELS-1-i] !== want[N_LEVELS-1-i])
						note_mismatch($sformatf("result %0d %s got %b want %b",
							results_seen, lane_name[i], got[N_LEVELS-1-i],
							want[N_LEVELS-1-i]));
			end
		end
	end

	// run limit
	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin : watchdog
		wait (cycle_count >= LIMIT);
		$display("simulation failed");
		$finish;
	end

endmodule
